/* rtl/frp_pkg.sv */
// Shared types, constants and helpers for the funnel restraint potential core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package frp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int ENERGY_W  = 47;
  localparam int FORCE_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYL_RADIUS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_POINT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONE_TANGENT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_CONST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_SLOPE   = 3'd5;

  typedef enum logic [1:0] {
    RGN_INSIDE = 2'd0,
    RGN_CURVED = 2'd1,
    RGN_CYL    = 2'd2,
    RGN_SLOPE  = 2'd3
  } region_t;

  typedef struct packed {
    logic        sphere_mode;
    logic [30:0] cyl_radius;
    logic [30:0] switch_point;
    logic [30:0] cone_tangent;
    logic [31:0] force_constant;
    logic [30:0] outer_slope;
  } cfg_t;

  // One classified point, handed from the front end to the back end.
  typedef struct packed {
    region_t     region;
    logic        s_neg;
    logic [31:0] abs_s;
    logic [30:0] z;
    logic [30:0] d;      // cone mode wall distance
    logic [30:0] zr;     // z - cyl_radius
    logic [63:0] nval;   // s*s + z*z, or z*z on the sloped wall
  } item_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [FORCE_W-1:0]  force_axial;
    logic [FORCE_W-1:0]  force_radial;
    region_t             region;
    logic                saturated;
  } result_t;

  typedef struct packed {
    logic               sat;
    logic [FORCE_W-1:0] val;
  } force_t;

  typedef enum logic [3:0] {
    B_IDLE, B_QDIV, B_QADD, B_QSQ, B_QSUM, B_SQRT, B_DIST, B_MUL, B_FDIV, B_DONE
  } bstate_t;

  // Clip a force magnitude to the signed output range and apply the sign.
  function automatic force_t clip_force(input logic [71:0] mag, input logic neg);
    logic [71:0]        lim;
    logic [FORCE_W-1:0] m;
    force_t             r;
    lim   = neg ? (72'd1 << (FORCE_W - 1)) : ((72'd1 << (FORCE_W - 1)) - 72'd1);
    r.sat = mag > lim;
    m     = r.sat ? lim[FORCE_W-1:0] : mag[FORCE_W-1:0];
    r.val = neg ? (FORCE_W'(0) - m) : m;
    return r;
  endfunction

endpackage

/* rtl/funnel_restraint_potential_core.sv */
// An inside point goes straight to the result register; a cone mode wall point runs the
// multiply steps; a sphere mode wall point adds the square root and force divide, the
// sloped wall a slope quotient before them. Throughput: the front end takes a point every
// cycle into a 4-entry queue unless stalled on a full queue; the back end sequencer ends one
// point before it pops the next (bit-serial square root and 64-step force divide).
// Reset: synchronous; clears the pipeline, queue and result valid flag and loads defaults.
`timescale 1ns / 1ps

module funnel_restraint_potential_core
  import frp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   axial_pos,
  input  logic [COORD_W-2:0]   radial_dist,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ENERGY_W-1:0]  energy,
  output logic [FORCE_W-1:0]   force_axial,
  output logic [FORCE_W-1:0]   force_radial,
  output logic [1:0]           region,
  output logic                 saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t    cfg;
  logic    q_push, q_full, q_pop, q_valid;
  item_t   f_item, q_item;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sphere_mode    <= 1'b0;
      cfg.cyl_radius     <= 31'd6554;
      cfg.switch_point   <= 31'd0;
      cfg.cone_tangent   <= 31'd412221;
      cfg.force_constant <= 32'd21504;
      cfg.outer_slope    <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPHERE_MODE:  cfg.sphere_mode    <= cfg_data[0];
        CFG_CYL_RADIUS:   cfg.cyl_radius     <= cfg_data[30:0];
        CFG_SWITCH_POINT: cfg.switch_point   <= cfg_data[30:0];
        CFG_CONE_TANGENT: cfg.cone_tangent   <= cfg_data[30:0];
        CFG_FORCE_CONST:  cfg.force_constant <= cfg_data;
        CFG_OUTER_SLOPE:  cfg.outer_slope    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  frp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .axial_pos   (axial_pos),
    .radial_dist (radial_dist),
    .push        (q_push),
    .item        (f_item),
    .full        (q_full)
  );

  frp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_item),
    .valid (q_valid)
  );

  frp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign energy       = res.energy;
  assign force_axial  = res.force_axial;
  assign force_radial = res.force_radial;
  assign region       = res.region;
  assign saturated    = res.saturated;

`ifndef ASSERT_OFF
  a_inside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == RGN_INSIDE |->
      energy == '0 && force_axial == '0 && force_radial == '0 && !saturated)
    else $error("inside point with nonzero result");

  a_slope_no_axial: assert property (@(posedge clk) disable iff (rst)
    out_valid && region == RGN_SLOPE |-> force_axial == '0)
    else $error("sloped wall with axial force");

  a_radial_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> force_radial[FORCE_W-1] || force_radial == '0)
    else $error("radial force points outward");
`endif

endmodule

/* rtl/frp_front.sv */
// Front end: accepts points and classifies them in a four-stage pipeline.
// Uses frp_pkg; pushes one item_t per point into the queue.
`timescale 1ns / 1ps

module frp_front
  import frp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] axial_pos,
  input  logic [COORD_W-2:0] radial_dist,
  output logic               push,
  output item_t              item,
  input  logic               full
);

  logic en;
  logic a_v, b_v, c_v, d_v;

  logic [31:0] a_s;
  logic [30:0] a_z;

  logic        b_neg, b_le, b_zge;
  logic [31:0] b_as, b_diff;
  logic [30:0] b_z, b_zr, b_sdz;

  logic        c_neg, c_le, c_zge;
  logic [31:0] c_as;
  logic [30:0] c_z, c_zr;
  logic [63:0] c_asq;
  logic [61:0] c_zsq, c_rcsq, c_zccsq, c_ms;
  logic [62:0] c_dt;

  logic        d_neg, d_le, d_zge;
  logic [31:0] d_as;
  logic [30:0] d_z, d_zr;
  logic [63:0] d_n, d_asrc;
  logic [61:0] d_zsq, d_zccsq, d_ms;
  logic [47:0] d_zmax;

  logic [32:0] diff_w, sdz_w;
  logic        sph;

  assign en       = !(d_v && full);
  assign in_ready = en;
  assign push     = d_v && !full;

  assign diff_w = {2'b00, cfg.switch_point} - {a_s[31], a_s};
  assign sdz_w  = {a_s[31], a_s} - {2'b00, cfg.switch_point};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_s <= axial_pos;
      a_z <= radial_dist;

      b_neg  <= a_s[31];
      b_le   <= sdz_w[32] || (sdz_w == 33'd0);
      b_as   <= a_s[31] ? (32'd0 - a_s) : a_s;
      b_diff <= diff_w[31:0];
      b_sdz  <= sdz_w[30:0];
      b_z    <= a_z;
      b_zge  <= a_z >= cfg.cyl_radius;
      b_zr   <= a_z - cfg.cyl_radius;

      c_neg   <= b_neg;
      c_le    <= b_le;
      c_zge   <= b_zge;
      c_as    <= b_as;
      c_z     <= b_z;
      c_zr    <= b_zr;
      c_asq   <= 64'(b_as) * 64'(b_as);
      c_zsq   <= 62'(b_z) * 62'(b_z);
      c_rcsq  <= 62'(cfg.cyl_radius) * 62'(cfg.cyl_radius);
      c_zccsq <= 62'(cfg.switch_point) * 62'(cfg.switch_point);
      c_dt    <= 63'(b_diff) * 63'(cfg.cone_tangent);
      c_ms    <= 62'(cfg.outer_slope) * 62'(b_sdz);

      d_neg   <= c_neg;
      d_le    <= c_le;
      d_zge   <= c_zge;
      d_as    <= c_as;
      d_z     <= c_z;
      d_zr    <= c_zr;
      d_n     <= c_asq + 64'(c_zsq);
      d_asrc  <= c_asq + 64'(c_rcsq);
      d_zsq   <= c_zsq;
      d_zccsq <= c_zccsq;
      d_ms    <= c_ms;
      d_zmax  <= 48'(c_dt[62:FRAC_BITS]) + 48'(cfg.cyl_radius);
    end
  end

  always_comb begin
    item        = '0;
    item.region = RGN_INSIDE;
    item.s_neg  = d_neg;
    item.abs_s  = d_as;
    item.z      = d_z;
    item.zr     = d_zr;
    item.nval   = d_n;
    sph = (cfg.switch_point >= cfg.cyl_radius) &&
          (d_neg || ({2'b00, d_zccsq} >= d_asrc));
    if (!cfg.sphere_mode) begin
      if (d_le) begin
        if ({17'd0, d_z} >= d_zmax) begin
          item.region = RGN_CURVED;
          item.d      = d_z - d_zmax[30:0];
        end
      end else if (d_zge) begin
        item.region = RGN_CYL;
        item.d      = d_zr;
      end
    end else if (sph) begin
      if (d_n >= {2'b00, d_zccsq}) begin
        item.region = RGN_CURVED;
      end
    end else if (d_zge) begin
      if (d_le || ({15'd0, d_zr, 16'd0} >= d_ms)) begin
        item.region = RGN_CYL;
      end else begin
        item.region = RGN_SLOPE;
        item.nval   = {2'b00, d_zsq};
      end
    end
  end

endmodule

/* rtl/frp_queue.sv */
// Short FIFO of classified points between the front and back ends.
// Uses frp_pkg for item_t and the depth constants.
`timescale 1ns / 1ps

module frp_queue
  import frp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  valid
);

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   cnt;
  logic              do_push, do_pop;

  assign full    = cnt == (QPTR_W + 1)'(QDEPTH);
  assign valid   = cnt != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

/* rtl/frp_back.sv */
// Back end: sequencer with a shared multiplier, bit-serial dividers and a square root unit.
// Uses frp_pkg; pops items from the queue and holds one result register.
`timescale 1ns / 1ps

module frp_back
  import frp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res
);

  bstate_t state, state_next;
  logic    load;

  item_t       it;
  logic [5:0]  cnt;
  logic [30:0] dv_rem;
  logic [31:0] dsh, quo, qv, rt, d, r1, r2;
  logic [63:0] prod, sn, acc_a, lo;
  logic [33:0] sq_rem;
  logic [95:0] ed, x1, x2;
  logic        ovalid;

  logic [31:0] mul_a, mul_b, w1;
  logic [95:0] psum;
  logic [31:0] dpre;
  logic        dge;
  logic [35:0] spre, strial;
  logic        sge;
  logic [32:0] f1pre, f2pre;
  logic        f1ge, f2ge;
  result_t     r;
  force_t      fr_c, fa_c;
  logic        e_sat;

  assign out_valid = ovalid;
  assign w1        = cfg.sphere_mode ? {1'b0, it.z} : {1'b0, cfg.cone_tangent};
  assign psum      = {prod, 32'd0} + {32'd0, lo};

  assign dpre = {dv_rem, dsh[31]};
  assign dge  = dpre >= {1'b0, cfg.outer_slope};

  assign spre   = {sq_rem, sn[63:62]};
  assign strial = {2'b00, rt, 2'b01};
  assign sge    = spre >= strial;

  assign f1pre = {r1, x1[63]};
  assign f2pre = {r2, x2[63]};
  assign f1ge  = f1pre >= {1'b0, rt};
  assign f2ge  = f2pre >= {1'b0, rt};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      B_QSQ: begin
        mul_a = qv;
        mul_b = qv;
      end
      B_MUL: begin
        case (cnt)
          6'd0:    begin mul_a = cfg.force_constant; mul_b = d;       end
          6'd2:    begin mul_a = acc_a[31:0];        mul_b = d;       end
          6'd3:    begin mul_a = acc_a[63:32];       mul_b = d;       end
          6'd4:    begin mul_a = acc_a[31:0];        mul_b = w1;      end
          6'd5:    begin mul_a = acc_a[63:32];       mul_b = w1;      end
          6'd6:    begin mul_a = acc_a[31:0];        mul_b = it.abs_s; end
          6'd7:    begin mul_a = acc_a[63:32];       mul_b = it.abs_s; end
          default: begin mul_a = '0;                 mul_b = '0;      end
        endcase
      end
      default: ;
    endcase
  end

  // final scaling and clipping of the result
  always_comb begin
    r        = '0;
    r.region = it.region;
    e_sat    = |ed[95:72];
    fr_c     = '0;
    fa_c     = '0;
    if (!cfg.sphere_mode) begin
      fr_c = clip_force({16'd0, acc_a[63:8]}, 1'b1);
      if (it.region == RGN_CURVED) fa_c = clip_force(x1[95:24], 1'b1);
    end else if (rt != '0) begin
      fr_c = clip_force({16'd0, x1[63:8]}, 1'b1);
      if (it.region != RGN_SLOPE) fa_c = clip_force({16'd0, x2[63:8]}, !it.s_neg);
    end
    if (it.region != RGN_INSIDE) begin
      r.energy       = e_sat ? '1 : ed[71:25];
      r.force_radial = fr_c.val;
      r.force_axial  = fa_c.val;
      r.saturated    = e_sat || fr_c.sat || fa_c.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.region == RGN_INSIDE) state_next = B_DONE;
          else if (!cfg.sphere_mode) state_next = B_MUL;
          else if (q_item.region == RGN_SLOPE) state_next = B_QDIV;
          else state_next = B_SQRT;
        end
      end
      B_QDIV:  if (cnt == 6'd31) state_next = B_QADD;
      B_QADD:  state_next = B_QSQ;
      B_QSQ:   state_next = B_QSUM;
      B_QSUM:  state_next = B_SQRT;
      B_SQRT:  if (cnt == 6'd31) state_next = B_DIST;
      B_DIST:  state_next = B_MUL;
      B_MUL: begin
        if (cnt == 6'd8) state_next = cfg.sphere_mode ? B_FDIV : B_DONE;
      end
      B_FDIV:  if (cnt == 6'd63) state_next = B_DONE;
      B_DONE: begin
        if (!ovalid || out_ready) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (load) ovalid <= 1'b1;
    else if (out_ready) ovalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (load) res <= r;
    case (state)
      B_IDLE: begin
        it     <= q_item;
        cnt    <= '0;
        d      <= {1'b0, q_item.d};
        sn     <= q_item.nval;
        sq_rem <= '0;
        rt     <= '0;
        dv_rem <= {16'd0, q_item.zr[30:16]};
        dsh    <= {q_item.zr[15:0], 16'd0};
        quo    <= '0;
      end
      B_QDIV: begin
        dv_rem <= dge ? 31'(dpre - {1'b0, cfg.outer_slope}) : dpre[30:0];
        quo    <= {quo[30:0], dge};
        dsh    <= {dsh[30:0], 1'b0};
        cnt    <= cnt + 1'b1;
      end
      B_QADD: qv <= quo + {1'b0, cfg.switch_point};
      B_QSUM: begin
        sn  <= prod + it.nval;
        cnt <= '0;
      end
      B_SQRT: begin
        sq_rem <= sge ? 34'(spre - strial) : spre[33:0];
        rt     <= {rt[30:0], sge};
        sn     <= {sn[61:0], 2'b00};
        cnt    <= cnt + 1'b1;
      end
      B_DIST: begin
        d   <= (rt > {1'b0, cfg.switch_point}) ? (rt - {1'b0, cfg.switch_point}) : '0;
        cnt <= '0;
      end
      B_MUL: begin
        cnt <= (cnt == 6'd8) ? '0 : cnt + 1'b1;
        case (cnt)
          6'd1:    acc_a <= prod;
          6'd3:    lo    <= prod;
          6'd4:    ed    <= psum;
          6'd5:    lo    <= prod;
          6'd6:    x1    <= psum;
          6'd7:    lo    <= prod;
          6'd8: begin
            x2 <= psum;
            r1 <= x1[95:64];
            r2 <= psum[95:64];
          end
          default: ;
        endcase
      end
      B_FDIV: begin
        // quotient bits shift in where the dividend bits leave
        r1         <= f1ge ? 32'(f1pre - {1'b0, rt}) : f1pre[31:0];
        r2         <= f2ge ? 32'(f2pre - {1'b0, rt}) : f2pre[31:0];
        x1[63:0]   <= {x1[62:0], f1ge};
        x2[63:0]   <= {x2[62:0], f2ge};
        cnt        <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* tb/sv/funnel_restraint_potential_core_tb.sv */
// Testbench for funnel_restraint_potential_core: directed and random points under several
// register settings, checked against an in-bench predictor. Depends on frp_pkg and the core.
`timescale 1ns / 1ps

module funnel_restraint_potential_core_tb;
  import frp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 200;

  typedef logic [255:0] wide_t;
  typedef struct {
    logic [COORD_W-1:0] s;
    logic [COORD_W-2:0] z;
  } point_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   axial_pos = '0;
  logic [COORD_W-2:0]   radial_dist = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ENERGY_W-1:0]  energy;
  logic [FORCE_W-1:0]   force_axial;
  logic [FORCE_W-1:0]   force_radial;
  logic [1:0]           region;
  logic                 saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  funnel_restraint_potential_core u_top (.*);

  always #6 clk = ~clk;

  point_t  points_to_send[$];
  result_t predicted_q[$];
  cfg_t    shadow_cfg;
  bit      in_taken = 0;
  bit      calm = 0;
  int      in_gap = 0;
  int      out_gap = 0;
  int      mismatches = 0;
  int      checked = 0;
  int      wall_hits = 0;
  int      sat_hits = 0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic wide_t isqrt(input wide_t n);
    wide_t r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (wide_t'(1) << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // floor(v / 2^sh), clipped to maxv
  function automatic wide_t clip_shift(input wide_t v, input int sh, input wide_t maxv,
                                       inout logic sat);
    wide_t m;
    m = v >> sh;
    if (m > maxv) begin
      sat = 1'b1;
      m = maxv;
    end
    return m;
  endfunction

  function automatic logic [FORCE_W-1:0] signed_force(input wide_t mag, input int sh,
                                                      input logic neg, inout logic sat);
    wide_t m;
    m = clip_shift(mag, sh, neg ? (wide_t'(1) << 47) : ((wide_t'(1) << 47) - 1), sat);
    return neg ? (FORCE_W'(0) - m[FORCE_W-1:0]) : m[FORCE_W-1:0];
  endfunction

  function automatic result_t funnel_response(input cfg_t c, input logic signed [31:0] s_in,
                                              input logic [30:0] z_in);
    longint  s;
    wide_t   as, z, rc, zcc, k, t, m, zmax, d, root, q, n, emax, qmax;
    logic    sat, wall, axial;
    result_t r;
    s = s_in;
    as = wide_t'(s < 0 ? -s : s);
    z = wide_t'(z_in);
    rc = wide_t'(c.cyl_radius);
    zcc = wide_t'(c.switch_point);
    k = wide_t'(c.force_constant);
    t = wide_t'(c.cone_tangent);
    m = wide_t'(c.outer_slope);
    emax = (wide_t'(1) << ENERGY_W) - 1;
    qmax = (wide_t'(1) << 64) - 1;
    sat = 1'b0;
    wall = 1'b0;
    axial = 1'b1;
    root = '0;
    r = '0;
    r.region = RGN_INSIDE;
    if (!c.sphere_mode) begin
      if (s <= longint'(c.switch_point)) begin
        zmax = ((wide_t'(longint'(c.switch_point) - s) * t) >> 16) + rc;
        if (z >= zmax) begin
          d = z - zmax;
          r.energy = ENERGY_W'(clip_shift(k * d * d, 25, emax, sat));
          r.force_radial = signed_force(k * d, 8, 1'b1, sat);
          r.force_axial = signed_force(k * d * t, 24, 1'b1, sat);
          r.region = RGN_CURVED;
        end
      end else if (z >= rc) begin
        d = z - rc;
        r.energy = ENERGY_W'(clip_shift(k * d * d, 25, emax, sat));
        r.force_radial = signed_force(k * d, 8, 1'b1, sat);
        r.region = RGN_CYL;
      end
    end else begin
      n = as * as + z * z;
      if (zcc >= rc && (s < 0 || zcc * zcc >= as * as + rc * rc)) begin
        if (n >= zcc * zcc) begin
          root = isqrt(n);
          wall = 1'b1;
          r.region = RGN_CURVED;
        end
      end else if (z >= rc) begin
        if (s <= longint'(c.switch_point) ||
            ((z - rc) << 16) >= m * wide_t'(s - longint'(c.switch_point))) begin
          root = isqrt(n);
          wall = 1'b1;
          r.region = RGN_CYL;
        end else begin
          q = ((z - rc) << 16) / m;
          if (q > qmax) q = qmax;
          q = (q > qmax - zcc) ? qmax : q + zcc;
          root = isqrt(q * q + z * z);
          wall = 1'b1;
          axial = 1'b0;
          r.region = RGN_SLOPE;
        end
      end
      if (wall) begin
        d = (root > zcc) ? root - zcc : '0;
        r.energy = ENERGY_W'(clip_shift(k * d * d, 25, emax, sat));
        if (root != 0) begin
          r.force_radial = signed_force((k * d * z) / root, 8, 1'b1, sat);
          if (axial) r.force_axial = signed_force((k * d * as) / root, 8, s >= 0, sat);
        end
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  // Driver: inputs move on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // hold until the transfer happens
      end else begin
        in_taken = 0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (points_to_send.size() > 0 && !calm && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(1, 19);
          in_valid <= 1'b0;
        end else if (points_to_send.size() > 0) begin
          point_t p;
          p = points_to_send.pop_front();
          in_valid <= 1'b1;
          axial_pos <= p.s;
          radial_dist <= p.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(1, 19);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor and predictor: sample on the rising edge.
  always @(posedge clk) begin
    if (rst) begin
      shadow_cfg.sphere_mode = 1'b0;
      shadow_cfg.cyl_radius = 31'd6554;
      shadow_cfg.switch_point = 31'd0;
      shadow_cfg.cone_tangent = 31'd412221;
      shadow_cfg.force_constant = 32'd21504;
      shadow_cfg.outer_slope = 31'd65536;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPHERE_MODE:  shadow_cfg.sphere_mode = cfg_data[0];
          CFG_CYL_RADIUS:   shadow_cfg.cyl_radius = cfg_data[30:0];
          CFG_SWITCH_POINT: shadow_cfg.switch_point = cfg_data[30:0];
          CFG_CONE_TANGENT: shadow_cfg.cone_tangent = cfg_data[30:0];
          CFG_FORCE_CONST:  shadow_cfg.force_constant = cfg_data;
          CFG_OUTER_SLOPE:  shadow_cfg.outer_slope = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predicted_q.push_back(funnel_response(shadow_cfg, axial_pos, radial_dist));
        in_taken = 1;
      end
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          flag_mismatch("result transfer with nothing predicted");
        end else begin
          result_t e;
          e = predicted_q.pop_front();
          checked++;
          if (e.region != RGN_INSIDE) wall_hits++;
          if (e.saturated) sat_hits++;
          if (energy !== e.energy)
            flag_mismatch($sformatf("energy %0h, predicted %0h", energy, e.energy));
          if (force_axial !== e.force_axial)
            flag_mismatch($sformatf("force_axial %0h, predicted %0h", force_axial,
                                    e.force_axial));
          if (force_radial !== e.force_radial)
            flag_mismatch($sformatf("force_radial %0h, predicted %0h", force_radial,
                                    e.force_radial));
          if (region !== e.region)
            flag_mismatch($sformatf("region %0d, predicted %0d", region, e.region));
          if (saturated !== e.saturated)
            flag_mismatch($sformatf("saturated %0b, predicted %0b", saturated, e.saturated));
        end
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk);
    while (points_to_send.size() > 0 || in_valid || predicted_q.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Call on a falling edge; returns on the falling edge after the transfer.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_cfg(input cfg_t c);
    @(negedge clk);
    write_reg(CFG_SPHERE_MODE, 32'(c.sphere_mode));
    write_reg(CFG_CYL_RADIUS, 32'(c.cyl_radius));
    write_reg(CFG_SWITCH_POINT, 32'(c.switch_point));
    write_reg(CFG_CONE_TANGENT, 32'(c.cone_tangent));
    write_reg(CFG_FORCE_CONST, c.force_constant);
    write_reg(CFG_OUTER_SLOPE, 32'(c.outer_slope));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [30:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 31'd0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(0, 8 << 16));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_cfg(input bit sphere);
    cfg_t c;
    c.sphere_mode = sphere;
    c.cyl_radius = ($urandom_range(0, 2) == 0) ? pick_coord() : 31'($urandom_range(0, 4 << 16));
    c.switch_point = ($urandom_range(0, 2) == 0) ? pick_coord() : 31'($urandom_range(0, 6 << 16));
    c.cone_tangent = ($urandom_range(0, 2) == 0) ? pick_coord() : 31'($urandom_range(0, 3 << 16));
    case ($urandom_range(0, 5))
      0: c.force_constant = 32'd0;
      1: c.force_constant = 32'hffff_ffff;
      2: c.force_constant = $urandom;
      default: c.force_constant = $urandom_range(1, 1 << 16);
    endcase
    c.outer_slope = pick_coord();
    if (c.outer_slope == 0) c.outer_slope = 31'd1;
    return c;
  endfunction

  // Most points sit near the switch point and the cylinder wall.
  function automatic point_t random_point(input cfg_t c);
    point_t p;
    longint sv, zv;
    if ($urandom_range(0, 7) == 0) begin
      p.s = $urandom;
    end else begin
      sv = longint'(c.switch_point) + longint'($urandom_range(0, 24 << 16)) - (12 << 16);
      p.s = sv[31:0];
    end
    if ($urandom_range(0, 7) == 0) begin
      p.z = 31'($urandom);
    end else begin
      zv = longint'(c.cyl_radius) + longint'($urandom_range(0, 16 << 16)) - (4 << 16);
      if (zv < 0) zv = 0;
      p.z = zv[30:0];
    end
    return p;
  endfunction

  task automatic add_point(input logic [31:0] s, input logic [30:0] z);
    point_t p;
    p.s = s;
    p.z = z;
    points_to_send.push_back(p);
  endtask

  initial begin
    cfg_t c;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // cone mode at reset values; a write to an unused index must change nothing
    c.sphere_mode = 1'b0;
    c.cyl_radius = 31'd6554;
    c.switch_point = 31'd0;
    c.cone_tangent = 31'd412221;
    c.force_constant = 32'd21504;
    c.outer_slope = 31'd65536;
    apply_cfg(c);
    @(negedge clk);
    write_reg(CFG_UNUSED, 32'hffff_ffff);
    cfg_valid <= 1'b0;
    add_point(32'd0, 31'd0);
    add_point(32'd0, 31'd6554);
    add_point(-(32'd1 << 16), 31'd1 << 20);
    add_point(32'd1 << 16, 31'd1 << 16);
    add_point(32'h8000_0000, 31'd0);
    add_point(32'h8000_0000, 31'h7fff_ffff);
    add_point(32'h7fff_ffff, 31'h7fff_ffff);
    add_point(32'h7fff_ffff, 31'd0);
    wait_drained();

    // sphere joined to cylinder: every region
    c.sphere_mode = 1'b1;
    c.cyl_radius = 31'd1 << 16;
    c.switch_point = 31'd3 << 16;
    apply_cfg(c);
    add_point(32'd0, 31'd0);
    add_point(32'd0, 31'd4 << 16);
    add_point(-(32'd5 << 16), 31'd0);
    add_point(32'd4 << 16, 31'd2 << 16);
    add_point(32'd8 << 16, 31'd2 << 16);
    add_point(32'd4 << 16, 31'd0);
    add_point(32'h7fff_ffff, 31'h7fff_ffff);
    wait_drained();

    // zero sphere radius, minimal slope, huge constant: zero distance and clipping
    c.cyl_radius = 31'd0;
    c.switch_point = 31'd0;
    c.outer_slope = 31'd1;
    c.force_constant = 32'hffff_ffff;
    apply_cfg(c);
    add_point(32'd0, 31'd0);
    add_point(32'h8000_0000, 31'h7fff_ffff);
    add_point(32'd9, 31'h7fff_ffff);
    wait_drained();

    // cylinder wider than the sphere: no sphere part at all
    c.cyl_radius = 31'd5 << 16;
    c.switch_point = 31'd2 << 16;
    c.force_constant = 32'd0;
    apply_cfg(c);
    add_point(-(32'd1 << 16), 31'd6 << 16);
    add_point(32'd0, 31'd1 << 16);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      c = random_cfg(ph[0]);
      if (ph == 5) calm = 1;
      apply_cfg(c);
      repeat (105) points_to_send.push_back(random_point(c));
      wait_drained();
    end

    $display("covered %0d results, %0d on a wall, %0d clipped, both funnel shapes",
             checked, wall_hits, sat_hits);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", predicted_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
